@@ hdl/gta_pkg.sv @@
// Shared types, constants and conversion functions for the gas and temperature alarm.
package gta_pkg;

  // Field widths fixed by the sensor and result formats.
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned GAS_W        = 20;
  localparam int unsigned TEMP_W       = 13;
  localparam int unsigned GAS_TOTAL_W  = 24;
  localparam int unsigned TEMP_TOTAL_W = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = GAS_W;

  // Register reset values.
  localparam logic [GAS_W-1:0]  GAS_LIMIT_RST  = GAS_W'(800);
  localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = TEMP_W'(400);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAS_LIMIT  = 1'b0,
    CFG_TEMP_LIMIT = 1'b1
  } gta_cfg_idx_t;

  // Gas power law: 16 * (600 / adc)^(5/3) is the largest v with
  // v^3 * adc^5 <= 4096 * 600^5.
  localparam int unsigned     GAS_ROM_DEPTH = 1 << SAMPLE_W;
  localparam logic [127:0]    GAS_NUMERATOR = 128'd318504960000000000;
  localparam logic [GAS_W-1:0] GAS_MAX      = '1;

  // Temperature scaling: adc * 5000 / 1023.
  localparam int unsigned TEMP_PROD_W = 23;
  localparam logic [TEMP_PROD_W-1:0] TEMP_SCALE   = TEMP_PROD_W'(5000);
  localparam logic [TEMP_PROD_W-1:0] TEMP_DIVISOR = TEMP_PROD_W'(1023);

  // Request payloads.
  typedef struct packed {
    logic [SAMPLE_W-1:0] gas_sample;
    logic [SAMPLE_W-1:0] temp_sample;
  } gta_in_t;

  typedef struct packed {
    logic [GAS_W-1:0]  gas_average;
    logic [TEMP_W-1:0] temp_average;
    logic              alarm;
    logic              alarm_changed;
  } gta_out_t;

  typedef logic [GAS_W-1:0] gas_rom_t [GAS_ROM_DEPTH];

  // Integer cube-root search of the gas power law, evaluated at elaboration.
  function automatic logic [GAS_W-1:0] gas_ppm(input logic [SAMPLE_W-1:0] a);
    logic [127:0] a5;
    logic [127:0] t;
    logic [GAS_W:0] v;
    int b;
    a5 = 128'(a) * 128'(a) * 128'(a) * 128'(a) * 128'(a);
    v  = '0;
    for (b = GAS_W; b >= 0; b--) begin
      t = 128'(v) | (128'd1 << b);
      if (t * t * t * a5 <= GAS_NUMERATOR) begin
        v = (GAS_W+1)'(t);
      end
    end
    if (a == '0 || v[GAS_W]) begin
      return GAS_MAX;
    end
    return v[GAS_W-1:0];
  endfunction

  // Full contents of the gas conversion table.
  function automatic gas_rom_t gas_rom_build();
    gas_rom_t rom;
    int i;
    for (i = 0; i < GAS_ROM_DEPTH; i++) begin
      rom[i] = gas_ppm(SAMPLE_W'(i));
    end
    return rom;
  endfunction

  // Divide by 1023 via the series 1/1024 * (1 + 2^-10 + 2^-20) and one correction.
  function automatic logic [TEMP_W-1:0] temp_convert(input logic [SAMPLE_W-1:0] a);
    logic [TEMP_PROD_W-1:0] x;
    logic [TEMP_PROD_W:0]   sum;
    logic [TEMP_PROD_W-SAMPLE_W:0] q;
    logic [TEMP_PROD_W-1:0] r;
    x   = TEMP_PROD_W'(a) * TEMP_SCALE;
    sum = (TEMP_PROD_W+1)'(x) + (TEMP_PROD_W+1)'(x >> 10) + (TEMP_PROD_W+1)'(x >> 20);
    q   = sum[TEMP_PROD_W:SAMPLE_W];
    r   = x - TEMP_PROD_W'(q) * TEMP_DIVISOR;
    if (r >= TEMP_DIVISOR) begin
      q = q + 1'b1;
    end
    return q[TEMP_W-1:0];
  endfunction

endpackage

@@ hdl/gta_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface gta_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/gta_convert.sv @@
// Input stage: gas power-law table lookup and temperature scaling, registered.
module gta_convert (
  input  logic                          clk,
  input  logic                          load,
  input  logic [gta_pkg::SAMPLE_W-1:0]  gas_sample,
  input  logic [gta_pkg::SAMPLE_W-1:0]  temp_sample,
  output logic [gta_pkg::GAS_W-1:0]     gas_value,
  output logic [gta_pkg::TEMP_W-1:0]    temp_value
);

  // Gas concentration table, one entry per converter code.
  localparam gta_pkg::gas_rom_t GAS_ROM = gta_pkg::gas_rom_build();

  logic [gta_pkg::GAS_W-1:0]  gas_value_r;
  logic [gta_pkg::TEMP_W-1:0] temp_value_r;

  // Registered table read and temperature conversion on each accepted request.
  always_ff @(posedge clk) begin
    if (load) begin
      gas_value_r  <= GAS_ROM[gas_sample];
      temp_value_r <= gta_pkg::temp_convert(temp_sample);
    end
  end

  assign gas_value  = gas_value_r;
  assign temp_value = temp_value_r;

endmodule

@@ hdl/gas_temp_averaging_alarm.sv @@
// Gas and temperature moving-average alarm, top level.
// The block takes one request per cycle unless stalled and returns one result for each: a
// table lookup stage converts the gas reading and scales the temperature, a window stage
// replaces the oldest slot and updates both running totals, a multiply stage divides the
// totals by the window depth through a constant reciprocal, and the output register holds
// the averages with the alarm and its change flag. Each stage holds its request while the
// next one is full, so a waiting result does not block new requests until all stages are
// occupied. Reset clears both windows and totals at once; there is no clearing pass. The
// user must write limits through the configuration port only while idle; it is not enforced.
module gas_temp_averaging_alarm #(
  parameter int unsigned WINDOW_DEPTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gta_stream_if.sink                      in_ch,
  gta_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [gta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gta_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned GAS_W   = gta_pkg::GAS_W;
  localparam int unsigned TEMP_W  = gta_pkg::TEMP_W;
  localparam int unsigned GTOT_W  = gta_pkg::GAS_TOTAL_W;
  localparam int unsigned TTOT_W  = gta_pkg::TEMP_TOTAL_W;
  localparam int unsigned PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // Reciprocal of the window depth, exact for every total of the given width.
  localparam int unsigned GAS_SHIFT  = GTOT_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned TEMP_SHIFT = TTOT_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned GAS_RCP_W  = GTOT_W + 1;
  localparam int unsigned TEMP_RCP_W = TTOT_W + 1;
  localparam int unsigned GAS_PROD_W  = GTOT_W + GAS_RCP_W;
  localparam int unsigned TEMP_PROD_W = TTOT_W + TEMP_RCP_W;
  localparam logic [GAS_RCP_W-1:0] GAS_RECIP =
    GAS_RCP_W'(((64'd1 << GAS_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
  localparam logic [TEMP_RCP_W-1:0] TEMP_RECIP =
    TEMP_RCP_W'(((64'd1 << TEMP_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

  // Configuration registers.
  logic [GAS_W-1:0]  gas_limit_r;
  logic [TEMP_W-1:0] temp_limit_r;

  // Stage valids and flow control.
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_take, s3_rdy, s2_rdy, s1_rdy;
  logic in_fire, s1_move, s2_move, s3_move;

  // Stage 1 payload from the conversion unit.
  logic [GAS_W-1:0]  gas_conv;
  logic [TEMP_W-1:0] temp_conv;

  // Window state.
  logic [GAS_W-1:0]  gas_win_r  [WINDOW_DEPTH];
  logic [TEMP_W-1:0] temp_win_r [WINDOW_DEPTH];
  logic [GTOT_W-1:0] gas_total_r, gas_total_nxt;
  logic [TTOT_W-1:0] temp_total_r, temp_total_nxt;
  logic [PTR_W-1:0]  slot_ptr_r, slot_ptr_nxt;

  // Stage 3 products.
  logic [GAS_PROD_W-1:0]  gas_prod_r;
  logic [TEMP_PROD_W-1:0] temp_prod_r;

  // Output stage.
  logic [GAS_W-1:0]  gas_avg;
  logic [TEMP_W-1:0] temp_avg;
  logic              alarm_nxt;
  logic              alarm_flag_r;
  gta_pkg::gta_out_t out_data_r;

  // Each stage takes a new request when it is empty or its content moves on.
  always_comb begin
    out_take = !out_v_r || out_ch.ready;
    s3_rdy   = !s3_v_r || out_take;
    s2_rdy   = !s2_v_r || s3_rdy;
    s1_rdy   = !s1_v_r || s2_rdy;
    in_fire  = in_ch.valid && s1_rdy;
    s1_move  = s1_v_r && s2_rdy;
    s2_move  = s2_v_r && s3_rdy;
    s3_move  = s3_v_r && out_take;
  end

  // No request is taken while reset is held.
  assign in_ch.ready  = s1_rdy && rst_n;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (out_take) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  // Configuration writes; an index outside the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_limit_r  <= gta_pkg::GAS_LIMIT_RST;
      temp_limit_r <= gta_pkg::TEMP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gta_pkg::CFG_GAS_LIMIT:  gas_limit_r  <= cfg_data[GAS_W-1:0];
        gta_pkg::CFG_TEMP_LIMIT: temp_limit_r <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: sensor conversion.
  gta_convert u_convert (
    .clk         (clk),
    .load        (in_fire),
    .gas_sample  (in_ch.data.gas_sample),
    .temp_sample (in_ch.data.temp_sample),
    .gas_value   (gas_conv),
    .temp_value  (temp_conv)
  );

  // Stage 2: drop the oldest slot from each total and add the new value.
  always_comb begin
    gas_total_nxt  = gas_total_r - GTOT_W'(gas_win_r[slot_ptr_r]) + GTOT_W'(gas_conv);
    temp_total_nxt = temp_total_r - TTOT_W'(temp_win_r[slot_ptr_r]) + TTOT_W'(temp_conv);
    slot_ptr_nxt   = (slot_ptr_r == PTR_LAST) ? '0 : slot_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        gas_win_r[i]  <= '0;
        temp_win_r[i] <= '0;
      end
      gas_total_r  <= '0;
      temp_total_r <= '0;
      slot_ptr_r   <= '0;
    end else if (s1_move) begin
      gas_win_r[slot_ptr_r]  <= gas_conv;
      temp_win_r[slot_ptr_r] <= temp_conv;
      gas_total_r  <= gas_total_nxt;
      temp_total_r <= temp_total_nxt;
      slot_ptr_r   <= slot_ptr_nxt;
    end
  end

  // Stage 3: totals times the reciprocal of the window depth.
  always_ff @(posedge clk) begin
    if (s2_move) begin
      gas_prod_r  <= GAS_PROD_W'(gas_total_r) * GAS_PROD_W'(GAS_RECIP);
      temp_prod_r <= TEMP_PROD_W'(temp_total_r) * TEMP_PROD_W'(TEMP_RECIP);
    end
  end

  // Output stage: averages, limit compare and alarm change.
  always_comb begin
    gas_avg   = gas_prod_r[GAS_SHIFT +: GAS_W];
    temp_avg  = temp_prod_r[TEMP_SHIFT +: TEMP_W];
    alarm_nxt = (gas_avg > gas_limit_r) || (temp_avg > temp_limit_r);
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_data_r.gas_average   <= gas_avg;
      out_data_r.temp_average  <= temp_avg;
      out_data_r.alarm         <= alarm_nxt;
      out_data_r.alarm_changed <= alarm_nxt != alarm_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_flag_r <= 1'b0;
    end else if (s3_move) begin
      alarm_flag_r <= alarm_nxt;
    end
  end

  // The stored alarm always matches the alarm of the result on display.
  ap_flag_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_data_r.alarm == alarm_flag_r))
    else $error("alarm flag differs from the held result");

  // The window slot pointer stays inside the window.
  ap_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_ptr_r <= PTR_LAST)
    else $error("slot pointer beyond window depth");

  // An empty output register lets the whole pipeline take a request.
  ap_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  // Totals hold while their stage waits on a full downstream stage.
  ap_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_rdy) |=> ($stable(gas_total_r) && $stable(temp_total_r)))
    else $error("running totals changed while stage two was stalled");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the gas and temperature moving-average alarm.
`timescale 1ns / 100ps

module testbench;

  localparam int WINDOW          = 10;
  localparam int TEMP_FULL_SCALE = 5000;
  localparam int ADC_SPAN        = 1023;
  localparam int HOLD_CYCLES     = 40;
  localparam longint unsigned GAS_LAW_BOUND = 64'd318504960000000000;

  // One directed request, with its result typed in where it is obvious.
  typedef struct {
    logic [gta_pkg::SAMPLE_W-1:0] gas;
    logic [gta_pkg::SAMPLE_W-1:0] temp;
    bit                           typed;
    gta_pkg::gta_out_t            want;
  } dir_row_t;

  // Per-request note on whether the expectation comes from the table.
  typedef struct {
    bit                typed;
    gta_pkg::gta_out_t want;
  } typed_hint_t;

  logic                           clk   = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [gta_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gta_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  gta_stream_if #(.payload_t(gta_pkg::gta_in_t))  in_if ();
  gta_stream_if #(.payload_t(gta_pkg::gta_out_t)) out_if ();

  gas_temp_averaging_alarm #(.WINDOW_DEPTH(WINDOW)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block state and limits.
  logic [gta_pkg::GAS_W-1:0]        gas_slots [WINDOW] = '{default: '0};
  logic [gta_pkg::TEMP_W-1:0]       temp_slots [WINDOW] = '{default: '0};
  logic [gta_pkg::GAS_TOTAL_W-1:0]  gas_sum     = '0;
  logic [gta_pkg::TEMP_TOTAL_W-1:0] temp_sum    = '0;
  int unsigned                      next_slot   = 0;
  logic                             alarm_state = 1'b0;
  logic [gta_pkg::GAS_W-1:0]        gas_limit_cur  = gta_pkg::GAS_LIMIT_RST;
  logic [gta_pkg::TEMP_W-1:0]       temp_limit_cur = gta_pkg::TEMP_LIMIT_RST;

  gta_pkg::gta_out_t averages_q [$];
  typed_hint_t       hint_q [$];

  int errors         = 0;
  int accepted       = 0;
  int results_seen   = 0;
  int alarm_edges    = 0;
  int stalled_cycles = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  logic sink_hold    = 1'b0;

  // Directed requests: window fill with saturated gas and full-scale temperature,
  // a full turnover to near-zero averages, then assorted bit patterns.
  dir_row_t dir_table [25] = '{
    '{10'd0,    10'd1023, 1'b1, '{20'd104857,  13'd500,  1'b1, 1'b1}},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b0, '0},
    '{10'd0,    10'd1023, 1'b1, '{20'd1048575, 13'd5000, 1'b1, 1'b0}},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0},
    '{10'd1023, 10'd0,    1'b1, '{20'd6,       13'd0,    1'b0, 1'b1}},
    '{10'h2AA,  10'h155,  1'b0, '0},
    '{10'h155,  10'h2AA,  1'b0, '0},
    '{10'd600,  10'd512,  1'b0, '0},
    '{10'd1,    10'd1,    1'b0, '0},
    '{10'd2,    10'd700,  1'b0, '0}
  };

  // Gas power law in 1/16 ppm: largest root with root^3 * reading^5 <= 4096 * 600^5.
  function automatic logic [gta_pkg::GAS_W-1:0] gas_to_sixteenths(
    input logic [gta_pkg::SAMPLE_W-1:0] reading
  );
    longint unsigned pow5;
    longint unsigned bound;
    longint unsigned root;
    longint unsigned trial;
    int bit_pos;
    if (reading == '0) begin
      return gta_pkg::GAS_MAX;
    end
    pow5  = 64'(reading);
    pow5  = pow5 * pow5 * pow5 * pow5 * pow5;
    bound = GAS_LAW_BOUND / pow5;
    root  = 0;
    for (bit_pos = gta_pkg::GAS_W; bit_pos >= 0; bit_pos--) begin
      trial = root | (64'd1 << bit_pos);
      if (trial * trial * trial <= bound) begin
        root = trial;
      end
    end
    if (root > 64'(gta_pkg::GAS_MAX)) begin
      return gta_pkg::GAS_MAX;
    end
    return root[gta_pkg::GAS_W-1:0];
  endfunction

  // Temperature in tenths of a degree, truncated.
  function automatic logic [gta_pkg::TEMP_W-1:0] temp_to_tenths(
    input logic [gta_pkg::SAMPLE_W-1:0] reading
  );
    int unsigned scaled;
    scaled = 32'(reading) * TEMP_FULL_SCALE;
    return gta_pkg::TEMP_W'(scaled / ADC_SPAN);
  endfunction

  // Push one reading pair through the shadow windows and derive the alarm.
  function automatic gta_pkg::gta_out_t advance_averages(input gta_pkg::gta_in_t req);
    logic [gta_pkg::GAS_W-1:0]  gas_val;
    logic [gta_pkg::TEMP_W-1:0] temp_val;
    gta_pkg::gta_out_t          res;
    gas_val  = gas_to_sixteenths(req.gas_sample);
    temp_val = temp_to_tenths(req.temp_sample);
    gas_sum  = gas_sum - gta_pkg::GAS_TOTAL_W'(gas_slots[next_slot])
               + gta_pkg::GAS_TOTAL_W'(gas_val);
    temp_sum = temp_sum - gta_pkg::TEMP_TOTAL_W'(temp_slots[next_slot])
               + gta_pkg::TEMP_TOTAL_W'(temp_val);
    gas_slots[next_slot]  = gas_val;
    temp_slots[next_slot] = temp_val;
    next_slot = (next_slot + 1) % WINDOW;
    res.gas_average   = gta_pkg::GAS_W'(gas_sum / WINDOW);
    res.temp_average  = gta_pkg::TEMP_W'(temp_sum / WINDOW);
    res.alarm         = (res.gas_average > gas_limit_cur) ||
                        (res.temp_average > temp_limit_cur);
    res.alarm_changed = (res.alarm != alarm_state);
    alarm_state       = res.alarm;
    return res;
  endfunction

  function automatic void compare_result(input gta_pkg::gta_out_t want,
                                         input gta_pkg::gta_out_t got);
    if (got.gas_average !== want.gas_average) begin
      $display("%0t: gas_average mismatch: expected %0d, got %0d",
               $time, want.gas_average, got.gas_average);
      errors++;
    end
    if (got.temp_average !== want.temp_average) begin
      $display("%0t: temp_average mismatch: expected %0d, got %0d",
               $time, want.temp_average, got.temp_average);
      errors++;
    end
    if (got.alarm !== want.alarm) begin
      $display("%0t: alarm mismatch: expected %0b, got %0b", $time, want.alarm, got.alarm);
      errors++;
    end
    if (got.alarm_changed !== want.alarm_changed) begin
      $display("%0t: alarm_changed mismatch: expected %0b, got %0b",
               $time, want.alarm_changed, got.alarm_changed);
      errors++;
    end
  endfunction

  // Track limit writes, accepted requests and returned results at each edge.
  always @(posedge clk) begin
    gta_pkg::gta_out_t predicted;
    typed_hint_t       hint;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          gta_pkg::CFG_GAS_LIMIT:  gas_limit_cur  = cfg_data;
          gta_pkg::CFG_TEMP_LIMIT: temp_limit_cur = cfg_data[gta_pkg::TEMP_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predicted = advance_averages(in_if.data);
        hint      = hint_q.pop_front();
        averages_q.push_back(hint.typed ? hint.want : predicted);
        accepted++;
      end
      if (in_if.valid && !in_if.ready) begin
        stalled_cycles++;
      end
      if (out_if.valid && out_if.ready) begin
        if (averages_q.size() == 0) begin
          $display("%0t: unexpected result: gas_average %0d temp_average %0d alarm %0b",
                   $time, out_if.data.gas_average, out_if.data.temp_average,
                   out_if.data.alarm);
          errors++;
        end else begin
          compare_result(averages_q.pop_front(), out_if.data);
        end
        results_seen++;
        if (out_if.data.alarm_changed) begin
          alarm_edges++;
        end
      end
    end
  end

  // Result side: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    out_if.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic hold_sink(input int cycles);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    sink_hold <= 1'b0;
  endtask

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_request(input gta_pkg::gta_in_t req, input bit typed,
                              input gta_pkg::gta_out_t want);
    typed_hint_t hint;
    hint.typed = typed;
    hint.want  = want;
    hint_q.push_back(hint);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Mostly mid and high gas readings, with some near zero to drive big averages.
  function automatic gta_pkg::gta_in_t draw_request();
    gta_pkg::gta_in_t req;
    case ($urandom_range(7))
      0:       req.gas_sample = gta_pkg::SAMPLE_W'($urandom_range(15));
      1, 2:    req.gas_sample = gta_pkg::SAMPLE_W'($urandom_range(1023));
      default: req.gas_sample = gta_pkg::SAMPLE_W'($urandom_range(1023, 150));
    endcase
    req.temp_sample = gta_pkg::SAMPLE_W'($urandom_range(1023));
    return req;
  endfunction

  // Wait until every expected result has come back, then a little longer.
  task automatic settle();
    @(posedge clk);
    while (averages_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limits(input logic [gta_pkg::CFG_DATA_W-1:0] gas_val,
                            input logic [gta_pkg::CFG_DATA_W-1:0] temp_val);
    cfg_we    <= 1'b1;
    cfg_index <= gta_pkg::CFG_GAS_LIMIT;
    cfg_data  <= gas_val;
    @(posedge clk);
    cfg_index <= gta_pkg::CFG_TEMP_LIMIT;
    cfg_data  <= temp_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) send_request(draw_request(), 1'b0, '0);
    in_if.valid <= 1'b0;
    settle();
  endtask

  // Run limit.
  initial begin
    #2_400_000;
    $display("FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    gta_pkg::gta_in_t               req;
    logic [gta_pkg::CFG_DATA_W-1:0] temp_word;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset limits, no idling.
    foreach (dir_table[i]) begin
      req.gas_sample  = dir_table[i].gas;
      req.temp_sample = dir_table[i].temp;
      send_request(req, dir_table[i].typed, dir_table[i].want);
    end
    in_if.valid <= 1'b0;
    settle();

    // Mid limits, no idling, and a long output hold-off that backs up the pipeline.
    set_limits(20'd2000, 20'd2500);
    fork
      hold_sink(HOLD_CYCLES);
      run_random(110, 0, 0);
    join

    // Both limits at zero, sparse requests.
    set_limits('0, '0);
    run_random(100, 71, 0);

    // Limits at their top, the temperature one above the output range.
    set_limits(gta_pkg::GAS_MAX, '1);
    run_random(100, 0, 71);

    // Random limits, junk in the unused upper data bits.
    temp_word = {7'($urandom), 13'($urandom_range(3500, 1500))};
    set_limits(gta_pkg::CFG_DATA_W'($urandom_range(20000, 100)), temp_word);
    run_random(110, 15, 15);

    // Temperature limit at full scale so only gas can alarm.
    set_limits(gta_pkg::CFG_DATA_W'($urandom_range(5000, 50)),
               gta_pkg::CFG_DATA_W'(TEMP_FULL_SCALE));
    run_random(105, 0, 0);

    $display("Summary: %0d requests accepted, %0d results checked, %0d alarm changes.",
             accepted, results_seen, alarm_edges);
    $display("Six limit settings incl. both extremes, four idle mixes, %0d input stall cycles.",
             stalled_cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
